// ===== sv/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define PWCM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// Checked at every edge, reset included.
`define PWCM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// ===== sv/pwcm_pkg.sv =====
`default_nettype none
package pwcm_pkg;
    localparam int COORD_W  = 12;
    localparam int COEF_W   = 48;
    localparam int PROD_W   = 61;
    localparam int SUM_W    = 64;
    localparam int MAG_W    = 63;
    localparam int QB_W     = 17;
    localparam int REM_W    = MAG_W + QB_W;
    localparam int SRC_W    = 16;
    localparam int NUM_REGS = 8;
    localparam int ADDR_W   = 3;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;
    localparam int FRONT_STAGES = 5;

    localparam int SRC_WIDTH_DEF  = 2048;
    localparam int SRC_HEIGHT_DEF = 2048;
    localparam int OUT_SIZE_DEF   = 4096;

    localparam logic [ADDR_W-1:0] REG_SX_BY_OX  = 3'd0;
    localparam logic [ADDR_W-1:0] REG_SX_BY_OY  = 3'd1;
    localparam logic [ADDR_W-1:0] REG_SX_OFFSET = 3'd2;
    localparam logic [ADDR_W-1:0] REG_SY_BY_OX  = 3'd3;
    localparam logic [ADDR_W-1:0] REG_SY_BY_OY  = 3'd4;
    localparam logic [ADDR_W-1:0] REG_SY_OFFSET = 3'd5;
    localparam logic [ADDR_W-1:0] REG_W_BY_OX   = 3'd6;
    localparam logic [ADDR_W-1:0] REG_W_BY_OY   = 3'd7;

    localparam logic [COEF_W-1:0] COEF_ONE  = 48'h0001_0000_0000;
    localparam logic [SUM_W-1:0]  Q32_ONE   = 64'h0000_0001_0000_0000;

    typedef logic [NUM_REGS-1:0][COEF_W-1:0] coef_bank_t;

    localparam coef_bank_t COEF_RESET = {{3{48'h0}}, COEF_ONE, {3{48'h0}}, COEF_ONE};

    typedef struct packed {
        logic [MAG_W-1:0] rem_x;
        logic [MAG_W-1:0] rem_y;
        logic [MAG_W-1:0] den;
        logic [QB_W-1:0]  q_x;
        logic [QB_W-1:0]  q_y;
        logic             ovf_x;
        logic             ovf_y;
        logic             sgn_x;
        logic             sgn_y;
        logic             kill;
    } cell_t;
endpackage
`default_nettype wire

// ===== sv/pwcm_front.sv =====
`default_nettype none
module pwcm_front #(
    parameter int OUT_SIZE = pwcm_pkg::OUT_SIZE_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire pwcm_pkg::coef_bank_t             coef,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [pwcm_pkg::COORD_W-1:0]     in_x,
    input  wire logic [pwcm_pkg::COORD_W-1:0]     in_y,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output pwcm_pkg::cell_t                       out_data
);
    localparam int NS = pwcm_pkg::FRONT_STAGES;
    localparam int CW = pwcm_pkg::COORD_W;

    logic [NS-1:0] v_reg, v_next, go;

    logic [CW-1:0] x1_reg, y1_reg;
    logic          k1_reg, k2_reg, k3_reg, k4_reg;
    logic signed [pwcm_pkg::PROD_W-1:0] p_reg [6];
    logic signed [pwcm_pkg::SUM_W-1:0]  nx_reg, ny_reg, dn_reg;
    logic [pwcm_pkg::MAG_W-1:0] mx_reg, my_reg, md_reg;
    logic sx_reg, sy_reg;
    pwcm_pkg::cell_t o_reg;

    logic signed [CW:0] xs, ys;
    logic signed [pwcm_pkg::SUM_W-1:0] offx, offy, one;
    logic [pwcm_pkg::REM_W-1:0] dsh;

    always_comb begin
        go[NS-1] = !v_reg[NS-1] || out_ready;
        for (int i = NS - 2; i >= 0; i--) begin
            go[i] = !v_reg[i] || go[i+1];
        end
        v_next[0] = go[0] ? in_valid : v_reg[0];
        for (int i = 1; i < NS; i++) begin
            v_next[i] = go[i] ? v_reg[i-1] : v_reg[i];
        end
        xs   = $signed({1'b0, x1_reg});
        ys   = $signed({1'b0, y1_reg});
        offx = pwcm_pkg::SUM_W'($signed(coef[pwcm_pkg::REG_SX_OFFSET]));
        offy = pwcm_pkg::SUM_W'($signed(coef[pwcm_pkg::REG_SY_OFFSET]));
        one  = $signed(pwcm_pkg::Q32_ONE);
        dsh  = {md_reg, {pwcm_pkg::QB_W{1'b0}}};
    end

    assign in_ready  = go[0];
    assign out_valid = v_reg[NS-1];
    assign out_data  = o_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
        if (go[0]) begin
            x1_reg <= in_x;
            y1_reg <= in_y;
            k1_reg <= ({1'b0, in_x} >= (CW+1)'(OUT_SIZE)) ||
                      ({1'b0, in_y} >= (CW+1)'(OUT_SIZE));
        end
        if (go[1]) begin
            p_reg[0] <= $signed(coef[pwcm_pkg::REG_SX_BY_OX]) * xs;
            p_reg[1] <= $signed(coef[pwcm_pkg::REG_SX_BY_OY]) * ys;
            p_reg[2] <= $signed(coef[pwcm_pkg::REG_SY_BY_OX]) * xs;
            p_reg[3] <= $signed(coef[pwcm_pkg::REG_SY_BY_OY]) * ys;
            p_reg[4] <= $signed(coef[pwcm_pkg::REG_W_BY_OX]) * xs;
            p_reg[5] <= $signed(coef[pwcm_pkg::REG_W_BY_OY]) * ys;
            k2_reg   <= k1_reg;
        end
        if (go[2]) begin
            nx_reg <= pwcm_pkg::SUM_W'(p_reg[0]) + pwcm_pkg::SUM_W'(p_reg[1]) + offx;
            ny_reg <= pwcm_pkg::SUM_W'(p_reg[2]) + pwcm_pkg::SUM_W'(p_reg[3]) + offy;
            dn_reg <= pwcm_pkg::SUM_W'(p_reg[4]) + pwcm_pkg::SUM_W'(p_reg[5]) + one;
            k3_reg <= k2_reg;
        end
        if (go[3]) begin
            mx_reg <= nx_reg[pwcm_pkg::SUM_W-1] ? pwcm_pkg::MAG_W'(-nx_reg)
                                                : pwcm_pkg::MAG_W'(nx_reg);
            my_reg <= ny_reg[pwcm_pkg::SUM_W-1] ? pwcm_pkg::MAG_W'(-ny_reg)
                                                : pwcm_pkg::MAG_W'(ny_reg);
            md_reg <= dn_reg[pwcm_pkg::SUM_W-1] ? pwcm_pkg::MAG_W'(-dn_reg)
                                                : pwcm_pkg::MAG_W'(dn_reg);
            sx_reg <= nx_reg[pwcm_pkg::SUM_W-1] ^ dn_reg[pwcm_pkg::SUM_W-1];
            sy_reg <= ny_reg[pwcm_pkg::SUM_W-1] ^ dn_reg[pwcm_pkg::SUM_W-1];
            k4_reg <= k3_reg || (dn_reg == '0);
        end
        if (go[4]) begin
            o_reg.rem_x <= mx_reg;
            o_reg.rem_y <= my_reg;
            o_reg.den   <= md_reg;
            o_reg.q_x   <= '0;
            o_reg.q_y   <= '0;
            o_reg.ovf_x <= {{pwcm_pkg::QB_W{1'b0}}, mx_reg} >= dsh;
            o_reg.ovf_y <= {{pwcm_pkg::QB_W{1'b0}}, my_reg} >= dsh;
            o_reg.sgn_x <= sx_reg;
            o_reg.sgn_y <= sy_reg;
            o_reg.kill  <= k4_reg;
        end
    end
endmodule
`default_nettype wire

// ===== sv/pwcm_div_cell.sv =====
`default_nettype none
module pwcm_div_cell #(
    parameter int BIT = 0
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire pwcm_pkg::cell_t in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output pwcm_pkg::cell_t      out_data
);
    logic            v_reg;
    pwcm_pkg::cell_t d_reg, d_next;
    logic [pwcm_pkg::REM_W-1:0] dsh, rx, ry;

    always_comb begin
        dsh    = pwcm_pkg::REM_W'(in_data.den) << BIT;
        rx     = pwcm_pkg::REM_W'(in_data.rem_x);
        ry     = pwcm_pkg::REM_W'(in_data.rem_y);
        d_next = in_data;
        if (rx >= dsh) begin
            d_next.rem_x  = pwcm_pkg::MAG_W'(rx - dsh);
            d_next.q_x[BIT] = 1'b1;
        end
        if (ry >= dsh) begin
            d_next.rem_y  = pwcm_pkg::MAG_W'(ry - dsh);
            d_next.q_y[BIT] = 1'b1;
        end
    end

    assign in_ready  = !v_reg || out_ready;
    assign out_valid = v_reg;
    assign out_data  = d_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
        if (in_ready) begin
            d_reg <= d_next;
        end
    end
endmodule
`default_nettype wire

// ===== sv/pwcm_back.sv =====
`default_nettype none
module pwcm_back #(
    parameter int SRC_WIDTH  = pwcm_pkg::SRC_WIDTH_DEF,
    parameter int SRC_HEIGHT = pwcm_pkg::SRC_HEIGHT_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire pwcm_pkg::cell_t               in_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [pwcm_pkg::SRC_W-1:0]         out_sx,
    output logic [pwcm_pkg::SRC_W-1:0]         out_sy,
    output logic                               out_in_range
);
    localparam int QW = pwcm_pkg::QB_W;
    localparam int SW = pwcm_pkg::SRC_W;
    localparam logic [QW-1:0] POS_MAX = QW'((1 << (SW - 1)) - 1);
    localparam logic [QW-1:0] NEG_MAX = QW'(1 << (SW - 1));

    logic v_reg;
    logic [SW-1:0] sx_reg, sy_reg, sx_next, sy_next;
    logic rng_reg, rng_next;
    logic neg_x, neg_y, ok_x, ok_y;

    always_comb begin
        neg_x = in_data.sgn_x && (in_data.ovf_x || in_data.q_x != '0);
        neg_y = in_data.sgn_y && (in_data.ovf_y || in_data.q_y != '0);
        if (neg_x) begin
            sx_next = (in_data.ovf_x || in_data.q_x > NEG_MAX) ? SW'(NEG_MAX)
                                                               : SW'(-in_data.q_x);
        end else begin
            sx_next = (in_data.ovf_x || in_data.q_x > POS_MAX) ? SW'(POS_MAX)
                                                               : SW'(in_data.q_x);
        end
        if (neg_y) begin
            sy_next = (in_data.ovf_y || in_data.q_y > NEG_MAX) ? SW'(NEG_MAX)
                                                               : SW'(-in_data.q_y);
        end else begin
            sy_next = (in_data.ovf_y || in_data.q_y > POS_MAX) ? SW'(POS_MAX)
                                                               : SW'(in_data.q_y);
        end
        ok_x = !neg_x && !in_data.ovf_x && (in_data.q_x < QW'(SRC_WIDTH));
        ok_y = !neg_y && !in_data.ovf_y && (in_data.q_y < QW'(SRC_HEIGHT));
        rng_next = ok_x && ok_y;
        if (in_data.kill) begin
            sx_next  = '0;
            sy_next  = '0;
            rng_next = 1'b0;
        end
    end

    assign in_ready     = !v_reg || out_ready;
    assign out_valid    = v_reg;
    assign out_sx       = sx_reg;
    assign out_sy       = sy_reg;
    assign out_in_range = rng_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
        if (in_ready) begin
            sx_reg  <= sx_next;
            sy_reg  <= sy_next;
            rng_reg <= rng_next;
        end
    end
endmodule
`default_nettype wire

// ===== sv/perspective_warp_coordinate_map.sv =====
// Perspective warp coordinate map.
// The slave stream takes one output pixel coordinate per word and the master
// stream returns the matching source coordinate, saturated to 16 bits signed,
// with tuser set when it lies inside the source frame, the input is below
// OUT_SIZE and the denominator is nonzero. The eight coefficients are to be
// written through the cfg port by the user only while the block is idle;
// the block does not enforce it. Reset loads the identity map. The pipeline
// has five front stages (input, multipliers, sums, magnitudes, overflow
// compare), seventeen divider cells that each settle one quotient bit for
// both coordinates, and the output register. Throughput is one word per
// cycle while m_tready is high. Every stage has its own valid bit, so a
// stall on m_tready fills empty stages before s_tready drops; the block
// keeps taking words while a finished result waits. Reset clears all valid
// bits and loads the identity map into the coefficient bank.
`default_nettype none
module perspective_warp_coordinate_map #(
    parameter int SRC_WIDTH  = pwcm_pkg::SRC_WIDTH_DEF,
    parameter int SRC_HEIGHT = pwcm_pkg::SRC_HEIGHT_DEF,
    parameter int OUT_SIZE   = pwcm_pkg::OUT_SIZE_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [pwcm_pkg::S_DATA_W-1:0]   s_tdata,  // out_x, out_y
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [pwcm_pkg::M_DATA_W-1:0]        m_tdata,  // src_x, src_y
    output logic                                 m_tuser,  // in_range
    input  wire logic                            cfg_we,
    input  wire logic [pwcm_pkg::ADDR_W-1:0]     cfg_addr,
    input  wire logic [pwcm_pkg::COEF_W-1:0]     cfg_wdata
);
    localparam int NC = pwcm_pkg::QB_W;
    localparam int CW = pwcm_pkg::COORD_W;

    pwcm_pkg::coef_bank_t coef_reg;

    logic            c_valid [NC+1];
    logic            c_ready [NC+1];
    pwcm_pkg::cell_t c_data  [NC+1];
    logic [pwcm_pkg::SRC_W-1:0] sx, sy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg <= pwcm_pkg::COEF_RESET;
        end else if (cfg_we) begin
            coef_reg[cfg_addr] <= cfg_wdata;
        end
    end

    pwcm_front #(.OUT_SIZE(OUT_SIZE)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .coef      (coef_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_x      (s_tdata[CW-1:0]),
        .in_y      (s_tdata[2*CW-1:CW]),
        .out_valid (c_valid[0]),
        .out_ready (c_ready[0]),
        .out_data  (c_data[0])
    );

    for (genvar i = 0; i < NC; i++) begin : g_cell
        pwcm_div_cell #(.BIT(NC - 1 - i)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (c_valid[i]),
            .in_ready  (c_ready[i]),
            .in_data   (c_data[i]),
            .out_valid (c_valid[i+1]),
            .out_ready (c_ready[i+1]),
            .out_data  (c_data[i+1])
        );
    end

    pwcm_back #(.SRC_WIDTH(SRC_WIDTH), .SRC_HEIGHT(SRC_HEIGHT)) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (c_valid[NC]),
        .in_ready     (c_ready[NC]),
        .in_data      (c_data[NC]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_sx       (sx),
        .out_sy       (sy),
        .out_in_range (m_tuser)
    );

    assign m_tdata = {sy, sx};
endmodule
`default_nettype wire

// ===== sv/pwcm_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module pwcm_checker #(
    parameter int SRC_WIDTH  = pwcm_pkg::SRC_WIDTH_DEF,
    parameter int SRC_HEIGHT = pwcm_pkg::SRC_HEIGHT_DEF
) (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [pwcm_pkg::M_DATA_W-1:0]   m_tdata,
    input wire logic                            m_tuser
);
    `PWCM_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_tvalid)
    `PWCM_ASSERT(a_stall_holds, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `PWCM_ASSERT(a_in_frame, aclk, aresetn, m_tvalid && m_tuser |-> !m_tdata[15] && !m_tdata[31] && (m_tdata[15:0] < 16'(SRC_WIDTH)) && (m_tdata[31:16] < 16'(SRC_HEIGHT)))
    `PWCM_ASSERT(a_backpressure_source, aclk, aresetn, !s_tready |-> m_tvalid && !m_tready)
endmodule

bind perspective_warp_coordinate_map pwcm_checker #(
    .SRC_WIDTH  (SRC_WIDTH),
    .SRC_HEIGHT (SRC_HEIGHT)
) u_pwcm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
`default_nettype none

typedef struct {
    logic signed [15:0] src_x;
    logic signed [15:0] src_y;
    logic               in_range;
} src_coord_t;

class warp_scoreboard;
    longint     coef[pwcm_pkg::NUM_REGS];
    src_coord_t pending[$];
    int         errors;

    function new();
        errors = 0;
        foreach (coef[i]) coef[i] = 0;
        coef[pwcm_pkg::REG_SX_BY_OX] = longint'(1) <<< 32;
        coef[pwcm_pkg::REG_SY_BY_OY] = longint'(1) <<< 32;
    endfunction

    function automatic logic signed [15:0] div_sat(longint num, longint den, int limit,
                                                   output logic in_frame);
        longint unsigned q;
        longint unsigned mn;
        longint unsigned md;
        mn = (num < 0) ? longint'(-num) : num;
        md = (den < 0) ? longint'(-den) : den;
        q = mn / md;
        if (((num < 0) != (den < 0)) && q != 0) begin
            in_frame = 1'b0;
            return (q > 32768) ? -16'sd32768 : -16'(q);
        end
        in_frame = (q < limit);
        return (q > 32767) ? 16'sd32767 : 16'(q);
    endfunction

    function void note_word(logic [11:0] ox, logic [11:0] oy);
        longint     x;
        longint     y;
        longint     den;
        longint     nx;
        longint     ny;
        logic       okx;
        logic       oky;
        src_coord_t r;
        x = longint'(ox);
        y = longint'(oy);
        r = '{0, 0, 1'b0};
        den = coef[pwcm_pkg::REG_W_BY_OX] * x + coef[pwcm_pkg::REG_W_BY_OY] * y
            + (longint'(1) <<< 32);
        if (x < pwcm_pkg::OUT_SIZE_DEF && y < pwcm_pkg::OUT_SIZE_DEF && den != 0) begin
            nx = coef[pwcm_pkg::REG_SX_BY_OX] * x + coef[pwcm_pkg::REG_SX_BY_OY] * y
               + coef[pwcm_pkg::REG_SX_OFFSET];
            ny = coef[pwcm_pkg::REG_SY_BY_OX] * x + coef[pwcm_pkg::REG_SY_BY_OY] * y
               + coef[pwcm_pkg::REG_SY_OFFSET];
            r.src_x = div_sat(nx, den, pwcm_pkg::SRC_WIDTH_DEF, okx);
            r.src_y = div_sat(ny, den, pwcm_pkg::SRC_HEIGHT_DEF, oky);
            r.in_range = okx & oky;
        end
        pending.push_back(r);
    endfunction

    function void check_word(logic [31:0] data, logic user);
        src_coord_t e;
        if (pending.size() == 0) begin
            $error("unexpected word %h", data);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (data[15:0] !== e.src_x) begin
            $error("src_x expected %0d actual %0d", e.src_x, $signed(data[15:0]));
            errors++;
        end
        if (data[31:16] !== e.src_y) begin
            $error("src_y expected %0d actual %0d", e.src_y, $signed(data[31:16]));
            errors++;
        end
        if (user !== e.in_range) begin
            $error("in_range expected %0d actual %0d", e.in_range, user);
            errors++;
        end
    endfunction
endclass

module tb;
    localparam int LIMIT = 400000;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [pwcm_pkg::S_DATA_W-1:0] s_tdata = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [pwcm_pkg::M_DATA_W-1:0] m_tdata;
    logic                          m_tuser;
    logic                          cfg_we = 1'b0;
    logic [pwcm_pkg::ADDR_W-1:0]   cfg_addr = '0;
    logic [pwcm_pkg::COEF_W-1:0]   cfg_wdata = '0;

    warp_scoreboard sb = new();
    bit             steady = 1'b0;
    int             cycles = 0;

    perspective_warp_coordinate_map u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("perspective_warp_coordinate_map verification failed");
            $finish;
        end
        m_tready <= steady || ($urandom_range(99) >= 24);
        if (aresetn && m_tvalid && m_tready)
            sb.check_word(m_tdata, m_tuser);
    end

    task automatic send_word(logic [11:0] x, logic [11:0] y);
        while (!steady && $urandom_range(99) < 24) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {y, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_word(x, y);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic load_bank(longint c[pwcm_pkg::NUM_REGS]);
        for (int i = 0; i < pwcm_pkg::NUM_REGS; i++) begin
            cfg_we <= 1'b1;
            cfg_addr <= pwcm_pkg::ADDR_W'(i);
            cfg_wdata <= c[i][pwcm_pkg::COEF_W-1:0];
            sb.coef[i] = c[i];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic longint rand_coef(int bits);
        longint v;
        v = {$urandom, $urandom};
        return (v <<< (64 - bits)) >>> (64 - bits);
    endfunction

    task automatic random_phase(int mode, int count);
        longint c[pwcm_pkg::NUM_REGS];
        for (int i = 0; i < pwcm_pkg::NUM_REGS; i++) begin
            if (mode == 0)
                c[i] = rand_coef(pwcm_pkg::COEF_W);
            else if (i >= 6)
                c[i] = rand_coef(mode == 1 ? 20 : 24);
            else
                c[i] = rand_coef(35);
        end
        if (mode == 3)
            c[pwcm_pkg::REG_SX_OFFSET] = rand_coef(44);
        load_bank(c);
        for (int n = 0; n < count; n++)
            send_word(12'($urandom), 12'($urandom));
        drain();
    endtask

    initial begin
        longint c[pwcm_pkg::NUM_REGS];
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_word(12'd0, 12'd0);
        send_word(12'd4095, 12'd4095);
        send_word(12'd2047, 12'd2047);
        send_word(12'd2048, 12'd5);
        drain();

        foreach (c[i]) c[i] = 0;
        c[pwcm_pkg::REG_W_BY_OX] = -(longint'(1) <<< 32);
        c[pwcm_pkg::REG_SX_BY_OX] = longint'(1) <<< 40;
        c[pwcm_pkg::REG_SY_BY_OY] = -(longint'(1) <<< 32);
        load_bank(c);
        send_word(12'd1, 12'd0);
        send_word(12'd0, 12'd7);
        send_word(12'd2, 12'd0);
        send_word(12'd4095, 12'd4095);
        drain();

        foreach (c[i]) c[i] = (i % 2) ? -(longint'(1) <<< 47) : (longint'(1) <<< 47) - 1;
        load_bank(c);
        send_word(12'd0, 12'd0);
        send_word(12'd4095, 12'd0);
        send_word(12'd0, 12'd4095);
        send_word(12'd4095, 12'd4095);
        send_word(12'd1, 12'd1);
        drain();

        foreach (c[i]) c[i] = (i % 2) ? (longint'(1) <<< 47) - 1 : -(longint'(1) <<< 47);
        c[pwcm_pkg::REG_W_BY_OX] = longint'(1) <<< 20;
        c[pwcm_pkg::REG_W_BY_OY] = -(longint'(1) <<< 19);
        load_bank(c);
        send_word(12'd0, 12'd0);
        send_word(12'd4095, 12'd4095);
        send_word(12'd100, 12'd3000);
        drain();

        steady = 1'b1;
        random_phase(2, 170);
        steady = 1'b0;
        for (int p = 0; p < 7; p++)
            random_phase(p % 4, 170);

        if (sb.errors == 0) begin
            $display("perspective_warp_coordinate_map verification clean");
        end else begin
            $display("perspective_warp_coordinate_map verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+sv
sv/pwcm_pkg.sv
sv/pwcm_front.sv
sv/pwcm_div_cell.sv
sv/pwcm_back.sv
sv/perspective_warp_coordinate_map.sv
sv/pwcm_checker.sv
verif/tb.sv
